FILE: design/ptc_pkg.sv
// Package for the pressure/temperature compensation pipeline.
// Holds field widths, datapath widths and register index codes.
// No dependencies.
package ptc_pkg;

  localparam int RAW_W     = 20;   // raw conversion result width
  localparam int CAL_W     = 48;   // calibration register width
  localparam int CFG_IDX_W = 2;    // register index width
  localparam int TC_W      = 16;   // temperature output width
  localparam int PR_W      = 32;   // pressure output width

  localparam int FINE_W    = 25;   // fine temperature, signed
  localparam int NUM_W     = 76;   // dividend magnitude
  localparam int DEN_W     = 40;   // divisor magnitude
  localparam int P_W       = NUM_W + 1;  // signed quotient
  localparam int DIV_STEPS = NUM_W;      // one quotient bit per stage

  // register index codes
  localparam logic [CFG_IDX_W-1:0] REG_CAL_T  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_PA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_PB = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_PC = 2'd3;

endpackage

FILE: design/pressure_temperature_compensation.sv
// Top level of the barometric compensation block: a fully pipelined
// integer datapath with a bit-per-stage divider. Depends on ptc_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | raw_temperature, raw_pressure
//  out     | out_valid / out_stall| temperature_centi, pressure_q24_8,
//          |                      | pressure_valid
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (cfg_ready is always 1)
//
// One beat enters per cycle while in_stall is low; each beat passes 7 stages of
// temperature and polynomial math, a sign stage and 76 divider stages, 8 stages
// of the final polynomial and one output register. The 76-stage restoring divider,
// one quotient bit per stage, makes up most of the pipeline depth.
// rst is synchronous and clears all valid bits and the calibration registers.
// A stalled output beat waits in the output register while the pipeline keeps
// moving; only when the last stage also holds a beat does in_stall rise.
module pressure_temperature_compensation
  import ptc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [RAW_W-1:0]            raw_temperature,
  input  logic [RAW_W-1:0]            raw_pressure,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [TC_W-1:0]      temperature_centi,
  output logic [PR_W-1:0]             pressure_q24_8,
  output logic                        pressure_valid,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CAL_W-1:0]            cfg_data
);

  // ------------------------------------------------------------------
  // Calibration registers. The user must write them only while the pipeline is
  // empty (the block does not enforce this), so every stage reads them directly.
  // ------------------------------------------------------------------
  logic [CAL_W-1:0] cal_temperature, cal_pressure_a, cal_pressure_b, cal_pressure_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temperature <= '0;
      cal_pressure_a  <= '0;
      cal_pressure_b  <= '0;
      cal_pressure_c  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CAL_T:  cal_temperature <= cfg_data;
        REG_CAL_PA: cal_pressure_a  <= cfg_data;
        REG_CAL_PB: cal_pressure_b  <= cfg_data;
        REG_CAL_PC: cal_pressure_c  <= cfg_data;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = cal_temperature[15:0];
  assign t2 = cal_temperature[31:16];
  assign t3 = cal_temperature[47:32];
  assign p1 = cal_pressure_a[15:0];
  assign p2 = cal_pressure_a[31:16];
  assign p3 = cal_pressure_a[47:32];
  assign p4 = cal_pressure_b[15:0];
  assign p5 = cal_pressure_b[31:16];
  assign p6 = cal_pressure_b[47:32];
  assign p7 = cal_pressure_c[15:0];
  assign p8 = cal_pressure_c[31:16];
  assign p9 = cal_pressure_c[47:32];

  // ------------------------------------------------------------------
  // Flow control: the whole pipeline advances together unless the last
  // stage holds a beat and the output register is full and stalled.
  // ------------------------------------------------------------------
  logic adv;
  logic r_v;

  assign adv      = !r_v || !out_valid || !out_stall;
  assign in_stall = !adv;

  // ------------------------------------------------------------------
  // Stage 1: linear temperature term and squared offset.
  // ------------------------------------------------------------------
  logic signed [17:0] d1;
  logic signed [16:0] dt;
  logic signed [33:0] dt_sq;
  logic               s1_v;
  logic signed [33:0] s1_tlin;
  logic [31:0]        s1_dtsq;
  logic [RAW_W-1:0]   s1_adcp;

  assign d1    = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign dt    = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
  assign dt_sq = dt * dt;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tlin <= d1 * t2;
      s1_dtsq <= dt_sq[31:0];   // square is never negative and below 2^32
      s1_adcp <= raw_pressure;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: fine temperature.
  // ------------------------------------------------------------------
  logic signed [36:0]       tb;
  logic                     s2_v;
  logic signed [FINE_W-1:0] s2_fine;
  logic [RAW_W-1:0]         s2_adcp;

  assign tb = $signed({1'b0, s1_dtsq[31:12]}) * t3;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_fine <= FINE_W'(s1_tlin >>> 11) + FINE_W'(tb >>> 14);
      s2_adcp <= s1_adcp;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: centidegrees with saturation; pressure offset term.
  // ------------------------------------------------------------------
  logic signed [27:0]       f5, tcw;
  logic signed [TC_W-1:0]   tc_sat;
  logic                     s3_v;
  logic signed [FINE_W-1:0] s3_a;
  logic signed [TC_W-1:0]   s3_tc;
  logic [RAW_W-1:0]         s3_adcp;

  assign f5  = 28'(s2_fine) * 28'sd5 + 28'sd128;
  assign tcw = f5 >>> 8;

  always_comb begin
    if (tcw > 28'sd32767)       tc_sat = 16'sh7fff;
    else if (tcw < -28'sd32768) tc_sat = 16'sh8000;
    else                        tc_sat = tcw[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_a    <= s2_fine - 25'sd128000;
      s3_tc   <= tc_sat;
      s3_adcp <= s2_adcp;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: square of the offset and its products with P5 and P2.
  // ------------------------------------------------------------------
  logic signed [49:0]     aa_full;
  logic                   s4_v;
  logic [47:0]            s4_aa;
  logic signed [40:0]     s4_ap5, s4_ap2;
  logic signed [TC_W-1:0] s4_tc;
  logic [RAW_W-1:0]       s4_adcp;

  assign aa_full = s3_a * s3_a;

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (adv) s4_v <= s3_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_aa   <= aa_full[47:0];
      s4_ap5  <= s3_a * p5;
      s4_ap2  <= s3_a * p2;
      s4_tc   <= s3_tc;
      s4_adcp <= s3_adcp;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: numerator correction b and the P3 square term.
  // ------------------------------------------------------------------
  logic signed [64:0]     aap6;
  logic                   s5_v;
  logic signed [65:0]     s5_b;
  logic signed [64:0]     s5_c3;
  logic signed [40:0]     s5_ap2;
  logic signed [TC_W-1:0] s5_tc;
  logic [RAW_W-1:0]       s5_adcp;

  assign aap6 = $signed({1'b0, s4_aa}) * p6;

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (adv) s5_v <= s4_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_b    <= 66'(aap6) + (66'(s4_ap5) <<< 17) + (66'(p4) <<< 35);
      s5_c3   <= $signed({1'b0, s4_aa}) * p3;
      s5_ap2  <= s4_ap2;
      s5_tc   <= s4_tc;
      s5_adcp <= s4_adcp;
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: divisor polynomial and raw numerator.
  // ------------------------------------------------------------------
  logic [20:0]            pdiff;
  logic                   s6_v;
  logic signed [57:0]     s6_a2;
  logic signed [66:0]     s6_nb;
  logic signed [TC_W-1:0] s6_tc;

  assign pdiff = 21'h100000 - {1'b0, s5_adcp};

  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (adv) s6_v <= s5_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_a2 <= 58'(s5_c3 >>> 8) + (58'(s5_ap2) <<< 12);
      s6_nb <= ($signed({46'd0, pdiff}) <<< 31) - 67'(s5_b);
      s6_tc <= s5_tc;
    end
  end

  // ------------------------------------------------------------------
  // Stage 7: scale the divisor by P1 and the numerator by 3125.
  // ------------------------------------------------------------------
  logic signed [57:0]     dbase;
  logic                   s7_v;
  logic signed [74:0]     s7_dp;
  logic signed [79:0]     s7_np;
  logic signed [TC_W-1:0] s7_tc;

  assign dbase = 58'sh800000000000 + s6_a2;

  always_ff @(posedge clk) begin
    if (rst) s7_v <= 1'b0;
    else if (adv) s7_v <= s6_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_dp <= dbase * $signed({1'b0, p1});
      s7_np <= s6_nb * $signed(13'd3125);
      s7_tc <= s6_tc;
    end
  end

  // ------------------------------------------------------------------
  // Divider. Element 0 holds magnitudes and signs; each later element
  // retires one quotient bit, shifting it in as the dividend shifts out.
  // ------------------------------------------------------------------
  logic signed [41:0]     dq;
  logic                   dv_v    [0:DIV_STEPS];
  logic [DEN_W-1:0]       dv_rem  [0:DIV_STEPS];
  logic [NUM_W-1:0]       dv_nq   [0:DIV_STEPS];
  logic [DEN_W-1:0]       dv_den  [0:DIV_STEPS];
  logic                   dv_neg  [0:DIV_STEPS];
  logic                   dv_zero [0:DIV_STEPS];
  logic signed [TC_W-1:0] dv_tc   [0:DIV_STEPS];

  assign dq = 42'(s7_dp >>> 33);

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (adv) dv_v[0] <= s7_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0]  <= '0;
      dv_nq[0]   <= s7_np[79] ? NUM_W'(-s7_np) : NUM_W'(s7_np);
      dv_den[0]  <= dq[41] ? DEN_W'(-dq) : DEN_W'(dq);
      dv_neg[0]  <= s7_np[79] ^ dq[41];
      dv_zero[0] <= (dq == '0);
      dv_tc[0]   <= s7_tc;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [DEN_W:0]   rem2;
    logic [DEN_W+1:0] diff;
    logic             ge;

    assign rem2 = {dv_rem[k-1], dv_nq[k-1][NUM_W-1]};
    assign diff = {1'b0, rem2} - {2'b0, dv_den[k-1]};
    assign ge   = !diff[DEN_W+1];

    always_ff @(posedge clk) begin
      if (rst) dv_v[k] <= 1'b0;
      else if (adv) dv_v[k] <= dv_v[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k]  <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
        dv_nq[k]   <= {dv_nq[k-1][NUM_W-2:0], ge};
        dv_den[k]  <= dv_den[k-1];
        dv_neg[k]  <= dv_neg[k-1];
        dv_zero[k] <= dv_zero[k-1];
        dv_tc[k]   <= dv_tc[k-1];
      end
    end
  end

  // ------------------------------------------------------------------
  // Quotient sign restore.
  // ------------------------------------------------------------------
  logic signed [P_W-1:0]  qpos;
  logic                   sp_v, sp_zero;
  logic signed [P_W-1:0]  sp_p;
  logic signed [TC_W-1:0] sp_tc;

  assign qpos = $signed({1'b0, dv_nq[DIV_STEPS]});

  always_ff @(posedge clk) begin
    if (rst) sp_v <= 1'b0;
    else if (adv) sp_v <= dv_v[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_p    <= dv_neg[DIV_STEPS] ? -qpos : qpos;
      sp_zero <= dv_zero[DIV_STEPS];
      sp_tc   <= dv_tc[DIV_STEPS];
    end
  end

  // ------------------------------------------------------------------
  // Q1: magnitude of p >> 13, P8 partial products.
  // ------------------------------------------------------------------
  logic signed [63:0]     q9;
  logic                   q1_v, q1_zero;
  logic [63:0]            q1_mag;
  logic signed [55:0]     q1_m8l;
  logic signed [53:0]     q1_m8h;
  logic signed [P_W-1:0]  q1_p;
  logic signed [TC_W-1:0] q1_tc;

  assign q9 = 64'(sp_p >>> 13);

  always_ff @(posedge clk) begin
    if (rst) q1_v <= 1'b0;
    else if (adv) q1_v <= sp_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_mag  <= q9[63] ? 64'(-q9) : 64'(q9);
      q1_m8l  <= $signed({1'b0, sp_p[38:0]}) * p8;
      q1_m8h  <= $signed(sp_p[P_W-1:39]) * p8;
      q1_p    <= sp_p;
      q1_zero <= sp_zero;
      q1_tc   <= sp_tc;
    end
  end

  // ------------------------------------------------------------------
  // Q2: square partial products; p + (P8 * p >> 19).
  // ------------------------------------------------------------------
  logic signed [92:0]     prod8;
  logic signed [73:0]     q8;
  logic                   q2_v, q2_zero;
  logic [63:0]            q2_hh, q2_hl, q2_ll;
  logic signed [77:0]     q2_s;
  logic signed [TC_W-1:0] q2_tc;

  assign prod8 = (93'(q1_m8h) <<< 39) + 93'(q1_m8l);
  assign q8    = 74'(prod8 >>> 19);

  always_ff @(posedge clk) begin
    if (rst) q2_v <= 1'b0;
    else if (adv) q2_v <= q1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q2_hh   <= q1_mag[63:32] * q1_mag[63:32];
      q2_hl   <= q1_mag[63:32] * q1_mag[31:0];
      q2_ll   <= q1_mag[31:0] * q1_mag[31:0];
      q2_s    <= 78'(q1_p) + 78'(q8);
      q2_zero <= q1_zero;
      q2_tc   <= q1_tc;
    end
  end

  // ------------------------------------------------------------------
  // Q3: assemble the 128-bit square.
  // ------------------------------------------------------------------
  logic                   q3_v, q3_zero;
  logic [127:0]           q3_sq;
  logic signed [77:0]     q3_s;
  logic signed [TC_W-1:0] q3_tc;

  always_ff @(posedge clk) begin
    if (rst) q3_v <= 1'b0;
    else if (adv) q3_v <= q2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q3_sq   <= {q2_hh, 64'd0} + (128'(q2_hl) << 33) + 128'(q2_ll);
      q3_s    <= q2_s;
      q3_zero <= q2_zero;
      q3_tc   <= q2_tc;
    end
  end

  // ------------------------------------------------------------------
  // Q4: P9 times the square, two halves.
  // ------------------------------------------------------------------
  logic                   q4_v, q4_zero;
  logic signed [80:0]     q4_h9, q4_l9;
  logic signed [77:0]     q4_s;
  logic signed [TC_W-1:0] q4_tc;

  always_ff @(posedge clk) begin
    if (rst) q4_v <= 1'b0;
    else if (adv) q4_v <= q3_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q4_h9   <= $signed({1'b0, q3_sq[127:64]}) * p9;
      q4_l9   <= $signed({1'b0, q3_sq[63:0]}) * p9;
      q4_s    <= q3_s;
      q4_zero <= q3_zero;
      q4_tc   <= q3_tc;
    end
  end

  // ------------------------------------------------------------------
  // Q5: combine halves, shift by 25.
  // ------------------------------------------------------------------
  logic signed [144:0]    prod9;
  logic                   q5_v, q5_zero;
  logic signed [119:0]    q5_q9t;
  logic signed [77:0]     q5_s;
  logic signed [TC_W-1:0] q5_tc;

  assign prod9 = (145'(q4_h9) <<< 64) + 145'(q4_l9);

  always_ff @(posedge clk) begin
    if (rst) q5_v <= 1'b0;
    else if (adv) q5_v <= q4_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q5_q9t  <= 120'(prod9 >>> 25);
      q5_s    <= q4_s;
      q5_zero <= q4_zero;
      q5_tc   <= q4_tc;
    end
  end

  // ------------------------------------------------------------------
  // Q6: full polynomial sum.
  // ------------------------------------------------------------------
  logic                   q6_v, q6_zero;
  logic signed [120:0]    q6_sum;
  logic signed [TC_W-1:0] q6_tc;

  always_ff @(posedge clk) begin
    if (rst) q6_v <= 1'b0;
    else if (adv) q6_v <= q5_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q6_sum  <= 121'(q5_q9t) + 121'(q5_s);
      q6_zero <= q5_zero;
      q6_tc   <= q5_tc;
    end
  end

  // ------------------------------------------------------------------
  // Last stage: add the P7 offset, saturate, force zero on a zero divisor.
  // ------------------------------------------------------------------
  logic signed [113:0]    tot;
  logic [PR_W-1:0]        pr_sat;
  logic signed [TC_W-1:0] r_tc;
  logic [PR_W-1:0]        r_pr;
  logic                   r_pv;

  assign tot = 114'(q6_sum >>> 8) + (114'(p7) <<< 4);

  always_comb begin
    if (tot[113])          pr_sat = '0;
    else if (|tot[112:32]) pr_sat = '1;
    else                   pr_sat = tot[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) r_v <= 1'b0;
    else if (adv) r_v <= q6_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_tc <= q6_tc;
      r_pr <= q6_zero ? '0 : pr_sat;
      r_pv <= !q6_zero;
    end
  end

  // ------------------------------------------------------------------
  // Output register: load whenever empty or being drained.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!out_valid || !out_stall) out_valid <= r_v;
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      temperature_centi <= r_tc;
      pressure_q24_8    <= r_pr;
      pressure_valid    <= r_pv;
    end
  end

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  a_zero_div_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pressure_valid |-> pressure_q24_8 == '0)
    else $error("pressure not cleared on zero divisor");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && r_v)
    else $error("input stalled without a blocked output beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat present after reset");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for pressure_temperature_compensation: drives raw
// readings, predicts the compensated outputs, checks each output beat.
// Depends on ptc_pkg and the RTL of the block.
module testbench;
  import ptc_pkg::*;

  // 192-bit signed word; wide enough that no product in the pressure path wraps
  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [RAW_W-1:0] temp_raw;
    logic [RAW_W-1:0] press_raw;
  } reading_t;

  typedef struct packed {
    logic signed [TC_W-1:0] centi;
    logic [PR_W-1:0]        pascal;
    logic                   pvalid;
  } comp_t;

  // Stall modes for the phases
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [RAW_W-1:0] raw_temperature = '0;
  logic [RAW_W-1:0] raw_pressure = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [TC_W-1:0] temperature_centi;
  logic [PR_W-1:0] pressure_q24_8;
  logic pressure_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAL_W-1:0] cfg_data = '0;

  // Bench copy of the calibration registers
  logic [CAL_W-1:0] cal_regs [4];

  reading_t   readings_pending[$];
  comp_t      comp_expected[$];
  idle_mode_t idle_mode = IDLE_NONE;
  logic       in_fire = 1'b0;
  int         mismatches = 0;
  logic       hold_req = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;

  pressure_temperature_compensation dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Compute the expected outputs for one reading under the current calibration.
  function automatic comp_t compensate(reading_t rd);
    longint adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint a, b, dt, fine, tc, dv;
    wide_t num, p, q9, q8, sum;
    comp_t r;
    adc_t = rd.temp_raw;
    adc_p = rd.press_raw;
    t1 = cal_regs[REG_CAL_T][15:0];
    t2 = $signed(cal_regs[REG_CAL_T][31:16]);
    t3 = $signed(cal_regs[REG_CAL_T][47:32]);
    p1 = cal_regs[REG_CAL_PA][15:0];
    p2 = $signed(cal_regs[REG_CAL_PA][31:16]);
    p3 = $signed(cal_regs[REG_CAL_PA][47:32]);
    p4 = $signed(cal_regs[REG_CAL_PB][15:0]);
    p5 = $signed(cal_regs[REG_CAL_PB][31:16]);
    p6 = $signed(cal_regs[REG_CAL_PB][47:32]);
    p7 = $signed(cal_regs[REG_CAL_PC][15:0]);
    p8 = $signed(cal_regs[REG_CAL_PC][31:16]);
    p9 = $signed(cal_regs[REG_CAL_PC][47:32]);

    // fine temperature, then hundredths of a degree, clamped to 16 bits
    a = (((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
    dt = (adc_t >>> 4) - t1;
    b = (((dt * dt) >>> 12) * t3) >>> 14;
    fine = a + b;
    tc = (fine * 5 + 128) >>> 8;
    if (tc > 32767) tc = 32767;
    if (tc < -32768) tc = -32768;
    r.centi = tc[15:0];

    // pressure polynomial and divisor
    a = fine - 128000;
    b = a * a * p6 + a * p5 * (longint'(1) << 17) + p4 * (longint'(1) << 35);
    a = ((a * a * p3) >>> 8) + a * p2 * (longint'(1) << 12);
    num = (wide_t'((longint'(1) << 47) + a) * wide_t'(p1)) >>> 33;
    dv = num[63:0];
    if (dv == 0) begin
      r.pascal = '0;
      r.pvalid = 1'b0;
      return r;
    end
    num = wide_t'((longint'(1048576) - adc_p) * (longint'(1) << 31) - b)
          * wide_t'(longint'(3125));
    p = num / wide_t'(dv);  // truncates toward zero
    q9 = p >>> 13;
    q9 = (wide_t'(p9) * q9 * q9) >>> 25;
    q8 = (wide_t'(p8) * p) >>> 19;
    sum = ((p + q9 + q8) >>> 8) + wide_t'(p7 * 16);
    if (sum < 0) r.pascal = '0;
    else if (sum[191:32] != 0) r.pascal = '1;
    else r.pascal = sum[31:0];
    r.pvalid = 1'b1;
    return r;
  endfunction

  // Sender: advance to the next reading once the current beat is taken.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (readings_pending.size() != 0 &&
          !((idle_mode == IDLE_SEND && $urandom_range(99) < 77) ||
            (idle_mode == IDLE_BOTH && $urandom_range(99) < 12))) begin
        reading_t rd;
        rd = readings_pending.pop_front();
        in_valid <= 1'b1;
        raw_temperature <= rd.temp_raw;
        raw_pressure <= rd.press_raw;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: a requested hold-off wins over random stalling.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (idle_mode == IDLE_RECV && $urandom_range(99) < 77) ||
                   (idle_mode == IDLE_BOTH && $urandom_range(99) < 12);
    end
  end

  // Input monitor: predict each accepted beat.
  always @(posedge clk) begin
    in_fire <= in_valid && !in_stall && !rst;
    if (!rst && in_valid && !in_stall)
      comp_expected.push_back(compensate('{raw_temperature, raw_pressure}));
  end

  // Output monitor: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (comp_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: centi %0d pascal %0h valid %0b",
                   temperature_centi, pressure_q24_8, pressure_valid);
      end else begin
        comp_t e;
        e = comp_expected.pop_front();
        if (e.centi !== temperature_centi || e.pascal !== pressure_q24_8 ||
            e.pvalid !== pressure_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: centi %0d/%0d pascal %0h/%0h valid %0b/%0b (exp/act)",
                     e.centi, temperature_centi, e.pascal, pressure_q24_8,
                     e.pvalid, pressure_valid);
        end
      end
    end
  end

  task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cal_regs[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_cal(logic [CAL_W-1:0] ct, pa, pb, pc);
    write_cal(REG_CAL_T, ct);
    write_cal(REG_CAL_PA, pa);
    write_cal(REG_CAL_PB, pb);
    write_cal(REG_CAL_PC, pc);
  endtask

  task automatic add_reading(logic [RAW_W-1:0] t, logic [RAW_W-1:0] pr);
    readings_pending.push_back('{t, pr});
  endtask

  // Mostly realistic readings, with full-range noise and the field extremes.
  task automatic add_random(int n);
    repeat (n) begin
      case ($urandom_range(9)) inside
        0: add_reading($urandom_range(1) ? '1 : '0, $urandom_range(1) ? '1 : '0);
        [1:2]: add_reading(RAW_W'($urandom), RAW_W'($urandom));
        default: add_reading(RAW_W'($urandom_range(560000, 400000)),
                             RAW_W'($urandom_range(480000, 250000)));
      endcase
    end
  endtask

  // Block until every reading is sent and every result is back.
  task automatic drain();
    @(posedge clk);
    while (readings_pending.size() != 0 || in_valid || comp_expected.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < 4; i++) cal_regs[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset calibration: zero divisor, pressure forced to 0
    add_reading('0, '0);
    add_reading('1, '1);
    add_reading(20'h80000, 20'h7FFFF);
    drain();

    // Typical calibration set, extremes of both raw fields
    load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
             {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
    add_reading('0, '0);
    add_reading('1, '1);
    add_reading('0, '1);
    add_reading('1, '0);
    add_reading(20'd519888, 20'd415148);
    add_reading(20'd1, 20'd1);
    add_reading(20'h55555, 20'hAAAAA);
    add_reading(20'hAAAAA, 20'h55555);
    drain();

    // All ones: every calibration bit set, extreme coefficients
    load_cal('1, '1, '1, '1);
    add_reading('0, '0);
    add_reading('1, '1);
    add_reading(20'd500000, 20'd300000);
    drain();

    // Signed extremes: most positive and most negative words
    load_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
             {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF});
    add_reading('0, '0);
    add_reading('1, '1);
    add_reading(20'd500000, 20'd300000);
    drain();
    load_cal({16'h8000, 16'h8000, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h0001},
             {16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000});
    add_reading('0, '1);
    add_reading('1, '0);
    add_reading(20'd450000, 20'd350000);
    drain();

    // Random phases; the idle mode cycles so every mode sees several settings
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0)
        load_cal({16'($urandom_range(65535)), 16'($urandom_range(30000, 20000)),
                  16'($urandom_range(65535, 64000))},
                 {16'($urandom_range(2000, 4000)), 16'($urandom_range(56000, 54000)),
                  16'($urandom_range(38000, 30000))},
                 {16'($urandom_range(65535, 65500)), 16'($urandom_range(200)),
                  16'($urandom_range(3000, 2000))},
                 {16'($urandom_range(7000, 5000)), 16'($urandom_range(52000, 50000)),
                  16'($urandom_range(16000, 14000))});
      else
        load_cal({16'($urandom), $urandom}, {16'($urandom), $urandom},
                 {16'($urandom), $urandom}, {16'($urandom), $urandom});
      idle_mode = idle_mode_t'(ph % 4);
      add_random(230);
      // long receiver hold-off while readings keep arriving, so the input backs up
      if (ph == 1) hold_req = ~hold_req;
      drain();
    end

    repeat (120) @(posedge clk);
    if (mismatches == 0 && comp_expected.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
